/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; the pair decode core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled in reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Assert that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pdcfc_pkg.sv */
// Package with constants and functions for the pair decode and CRC-16 frame check.
`default_nettype none

package pdcfc_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam int unsigned RSP_DATA_W = 48;
   localparam logic [8:0] LEN_MASK = 9'h1ff;

   function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
      logic [15:0] w;
      logic [7:0] d;
      w = {hi, lo};
      for (int b = 0; b < 8; b++) begin
         d[b] = w[2*b+1] ^ w[2*b];
      end
      return d;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
      logic [15:0] c;
      logic top;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         top = c[15] ^ v[k];
         c = {c[14:0], 1'b0};
         if (top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/pair_decode_crc16_frame_check_core.sv */
// Pair decoder with CRC-16 trailer search over a stream of line-coded bytes.
//
// Usage: raw line-coded bytes enter on the req_ channel, one per word, with
// req_tlast on the final raw byte of a frame. Two raw bytes form one decoded
// byte; the first of a pair is held and gives no result unless it ends the
// frame, in which case it is decoded with a zero low half. Each decoded byte
// leaves on the rsp_ channel with its position, the frame status so far
// (valid flag, length, CRC of the first matching trailer) and rsp_tlast on
// the byte that ends the frame.
// A result is registered and presented in the cycle after the raw byte that
// completes its pair is accepted. Throughput: one raw byte per cycle while the
// receiver takes each result, set by the single result register; the CRC
// update is one byte per cycle. When the receiver stalls, the result register
// holds and req_tready drops until the result is taken. Reset clears all frame
// state and empties the result register; the end of each frame returns the
// state to the same reset values.
`default_nettype none

module pair_decode_crc16_frame_check_core
   import pdcfc_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // raw_byte[7:0]
   input  wire logic                  req_tlast,   // frame_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // decoded_byte[7:0], byte_position[15:8],
                                                   // frame_valid[16], valid_length[25:17],
                                                   // found_crc[41:26], zero[47:42]
   output logic                       rsp_tlast    // is_last
);

   `include "assert_macros.svh"

   localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned PW = (CW > 8) ? CW : 8;

   logic [7:0]    pending_raw_ff, pending_raw_in;
   logic          pair_phase_ff, pair_phase_in;
   logic [15:0]   running_crc_ff, running_crc_in;
   logic [15:0]   crc_before_last_ff, crc_before_last_in;
   logic [7:0]    previous_decoded_ff, previous_decoded_in;
   logic [CW-1:0] count_ff, count_in;
   logic          match_found_ff, match_found_in;
   logic [8:0]    match_length_ff, match_length_in;
   logic [15:0]   match_crc_ff, match_crc_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [7:0]    rsp_pos_ff, rsp_pos_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          emit;
   logic [7:0]    hi_byte, lo_byte, decoded;
   logic          in_range;
   logic          match_hit;
   logic [CW-1:0] pos_full;
   logic [PW-1:0] pos_wide;
   logic [PW:0]   len_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign emit       = accept && (pair_phase_ff || req_tlast);

   always_comb begin
      hi_byte   = pair_phase_ff ? pending_raw_ff : req_tdata;
      lo_byte   = pair_phase_ff ? req_tdata : 8'h00;
      decoded   = decode_pair(hi_byte, lo_byte);
      in_range  = (count_ff < CW'(MAX_FRAME_BYTES));
      match_hit = in_range && !match_found_ff && (count_ff >= CW'(3)) &&
                  (previous_decoded_ff == crc_before_last_ff[15:8]) &&
                  (decoded == crc_before_last_ff[7:0]);
      pos_full  = in_range ? count_ff : CW'(MAX_FRAME_BYTES - 1);
      pos_wide  = PW'(pos_full);
      len_wide  = (PW + 1)'(count_ff) + (PW + 1)'(1);
   end

   always_comb begin
      pending_raw_in      = pending_raw_ff;
      pair_phase_in       = pair_phase_ff;
      running_crc_in      = running_crc_ff;
      crc_before_last_in  = crc_before_last_ff;
      previous_decoded_in = previous_decoded_ff;
      count_in            = count_ff;
      match_found_in      = match_found_ff;
      match_length_in     = match_length_ff;
      match_crc_in        = match_crc_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_tready;
      rsp_byte_in         = rsp_byte_ff;
      rsp_pos_in          = rsp_pos_ff;
      rsp_last_in         = rsp_last_ff;
      if (accept && !emit) begin
         pending_raw_in = req_tdata;
         pair_phase_in  = 1'b1;
      end
      if (emit) begin
         pair_phase_in = 1'b0;
         if (match_hit) begin
            match_found_in  = 1'b1;
            match_crc_in    = crc_before_last_ff;
            match_length_in = len_wide[8:0] & LEN_MASK;
         end
         if (in_range) begin
            count_in = count_ff + CW'(1);
         end
         crc_before_last_in  = running_crc_ff;
         running_crc_in      = crc_byte(running_crc_ff, decoded);
         previous_decoded_in = decoded;
         rsp_valid_in        = 1'b1;
         rsp_byte_in         = decoded;
         rsp_pos_in          = (pos_wide > PW'(255)) ? 8'hff : pos_wide[7:0];
         rsp_last_in         = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (emit && req_tlast)) begin
         pending_raw_ff      <= '0;
         pair_phase_ff       <= 1'b0;
         running_crc_ff      <= '0;
         crc_before_last_ff  <= '0;
         previous_decoded_ff <= '0;
         count_ff            <= '0;
         match_found_ff      <= 1'b0;
         match_length_ff     <= '0;
         match_crc_ff        <= '0;
      end else begin
         pending_raw_ff      <= pending_raw_in;
         pair_phase_ff       <= pair_phase_in;
         running_crc_ff      <= running_crc_in;
         crc_before_last_ff  <= crc_before_last_in;
         previous_decoded_ff <= previous_decoded_in;
         count_ff            <= count_in;
         match_found_ff      <= match_found_in;
         match_length_ff     <= match_length_in;
         match_crc_ff        <= match_crc_in;
      end
   end

   logic          rsp_valid_flag_ff;
   logic [8:0]    rsp_len_ff;
   logic [15:0]   rsp_crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
      if (emit) begin
         rsp_valid_flag_ff <= match_found_in;
         rsp_len_ff        <= match_length_in;
         rsp_crc_ff        <= match_crc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_crc_ff, rsp_len_ff, rsp_valid_flag_ff, rsp_pos_ff, rsp_byte_ff};

   `ASSERT_CLK(a_no_match_clear, !match_found_ff |-> (match_crc_ff == 16'h0000 &&
      match_length_ff == 9'h000), "match length or CRC set without a match")
   `ASSERT_NEXT(a_frame_end_clears, accept && req_tlast, (!pair_phase_ff && count_ff == '0 &&
      !match_found_ff && running_crc_ff == 16'h0000), "frame state not cleared after frame end")
   `ASSERT_NEXT(a_pair_gives_word, emit, rsp_tvalid, "completed pair produced no result word")
   `ASSERT_NEXT(a_first_byte_held, accept && !pair_phase_ff && !req_tlast,
      (pair_phase_ff && !rsp_valid_in || pair_phase_ff), "first byte of a pair not held")

endmodule

`default_nettype wire
